// File: rtl/least_squares_cell_gradient_defines.svh
// ----------------------------------------------------------------------------
// Least-squares cell gradient assertion macros
// Shared concurrent assertion forms for the gradient block.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_CELL_GRADIENT_DEFINES_SVH
`define LEAST_SQUARES_CELL_GRADIENT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSCG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lscg_pkg.sv
// ----------------------------------------------------------------------------
// Least-squares cell gradient package
// Shared types, codes and the solver micro-program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lscg_pkg;

    localparam logic [1:0] DIM_2D    = 2'd2;
    localparam logic [1:0] DIM_RESET = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SING = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    // Operand codes: accumulated sums, then the temporary registers.
    localparam logic [3:0] SRC_XX = 4'd0;
    localparam logic [3:0] SRC_XY = 4'd1;
    localparam logic [3:0] SRC_XZ = 4'd2;
    localparam logic [3:0] SRC_YY = 4'd3;
    localparam logic [3:0] SRC_YZ = 4'd4;
    localparam logic [3:0] SRC_ZZ = 4'd5;
    localparam logic [3:0] SRC_RX = 4'd6;
    localparam logic [3:0] SRC_RY = 4'd7;
    localparam logic [3:0] SRC_RZ = 4'd8;
    localparam logic [3:0] SRC_T0 = 4'd9;
    localparam logic [3:0] SRC_T1 = 4'd10;
    localparam logic [3:0] SRC_T2 = 4'd11;
    localparam logic [3:0] SRC_T3 = 4'd12;
    localparam logic [3:0] SRC_T4 = 4'd13;
    localparam logic [3:0] SRC_T5 = 4'd14;

    localparam int          NUM_PAIRS = 9;
    localparam int          MAC_BITS  = 64;
    localparam logic [2:0]  DET_SLOT  = 3'd6;
    localparam logic [4:0]  PC_3D     = 5'd0;
    localparam logic [4:0]  PC_2D     = 5'd24;

    typedef enum logic [1:0] {
        UA_NONE,
        UA_STORE,
        UA_DET,
        UA_DIV
    } uop_act_t;

    typedef struct packed {
        logic [3:0] x_sel;
        logic [3:0] y_sel;
        logic       neg;
        logic       clr;
        uop_act_t   act;
        logic [2:0] dst;
        logic [1:0] gidx;
        logic       fin;
    } uop_t;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       add_en;
        logic [3:0] add_sel;
        logic       sum_clear;
        logic       mac_load;
        logic       mac_step;
        logic       mac_top;
        logic       t_store;
        logic       div_load;
        logic       div_step;
        logic       div_round;
        logic       div_write;
        logic       g_clear;
        logic       out_load;
        uop_t       uop;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
    } dp_status_t;

    function automatic uop_t mk_uop(input logic [3:0] x_sel, input logic [3:0] y_sel,
                                    input logic neg, input logic clr, input uop_act_t act,
                                    input logic [2:0] dst, input logic [1:0] gidx,
                                    input logic fin);
        uop_t u;
        u.x_sel = x_sel;
        u.y_sel = y_sel;
        u.neg   = neg;
        u.clr   = clr;
        u.act   = act;
        u.dst   = dst;
        u.gidx  = gidx;
        u.fin   = fin;
        return u;
    endfunction

    // The 3D program builds the six cofactors, the determinant and the three
    // Cramer numerators. The 2D program uses the 2x2 forms directly.
    function automatic uop_t uop_at(input logic [4:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk_uop(SRC_YY, SRC_ZZ, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd1:  u = mk_uop(SRC_YZ, SRC_YZ, 1'b1, 1'b0, UA_STORE, 3'd0, 2'd0, 1'b0);
            5'd2:  u = mk_uop(SRC_XZ, SRC_YZ, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd3:  u = mk_uop(SRC_XY, SRC_ZZ, 1'b1, 1'b0, UA_STORE, 3'd1, 2'd0, 1'b0);
            5'd4:  u = mk_uop(SRC_XY, SRC_YZ, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd5:  u = mk_uop(SRC_YY, SRC_XZ, 1'b1, 1'b0, UA_STORE, 3'd2, 2'd0, 1'b0);
            5'd6:  u = mk_uop(SRC_XX, SRC_ZZ, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd7:  u = mk_uop(SRC_XZ, SRC_XZ, 1'b1, 1'b0, UA_STORE, 3'd3, 2'd0, 1'b0);
            5'd8:  u = mk_uop(SRC_XY, SRC_XZ, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd9:  u = mk_uop(SRC_XX, SRC_YZ, 1'b1, 1'b0, UA_STORE, 3'd4, 2'd0, 1'b0);
            5'd10: u = mk_uop(SRC_XX, SRC_YY, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd11: u = mk_uop(SRC_XY, SRC_XY, 1'b1, 1'b0, UA_STORE, 3'd5, 2'd0, 1'b0);
            5'd12: u = mk_uop(SRC_T0, SRC_XX, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd13: u = mk_uop(SRC_T1, SRC_XY, 1'b0, 1'b0, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd14: u = mk_uop(SRC_T2, SRC_XZ, 1'b0, 1'b0, UA_DET,   DET_SLOT, 2'd0, 1'b0);
            5'd15: u = mk_uop(SRC_T0, SRC_RX, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd16: u = mk_uop(SRC_T1, SRC_RY, 1'b0, 1'b0, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd17: u = mk_uop(SRC_T2, SRC_RZ, 1'b0, 1'b0, UA_DIV,   3'd0, 2'd0, 1'b0);
            5'd18: u = mk_uop(SRC_T1, SRC_RX, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd19: u = mk_uop(SRC_T3, SRC_RY, 1'b0, 1'b0, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd20: u = mk_uop(SRC_T4, SRC_RZ, 1'b0, 1'b0, UA_DIV,   3'd0, 2'd1, 1'b0);
            5'd21: u = mk_uop(SRC_T2, SRC_RX, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd22: u = mk_uop(SRC_T4, SRC_RY, 1'b0, 1'b0, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd23: u = mk_uop(SRC_T5, SRC_RZ, 1'b0, 1'b0, UA_DIV,   3'd0, 2'd2, 1'b1);
            5'd24: u = mk_uop(SRC_XX, SRC_YY, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd25: u = mk_uop(SRC_XY, SRC_XY, 1'b1, 1'b0, UA_DET,   DET_SLOT, 2'd0, 1'b0);
            5'd26: u = mk_uop(SRC_RX, SRC_YY, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd27: u = mk_uop(SRC_XY, SRC_RY, 1'b1, 1'b0, UA_DIV,   3'd0, 2'd0, 1'b0);
            5'd28: u = mk_uop(SRC_XX, SRC_RY, 1'b0, 1'b1, UA_NONE,  3'd0, 2'd0, 1'b0);
            5'd29: u = mk_uop(SRC_RX, SRC_XY, 1'b1, 1'b0, UA_DIV,   3'd0, 2'd1, 1'b1);
            default: u = mk_uop(SRC_XX, SRC_XX, 1'b0, 1'b1, UA_NONE, 3'd0, 2'd0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/lscg_datapath.sv
// ----------------------------------------------------------------------------
// Least-squares cell gradient datapath
// Operand capture, product accumulation, shift-add MAC, temporaries and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscg_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int BIG_W     = 210
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lscg_pkg::dp_cmd_t       cmd,
    output lscg_pkg::dp_status_t    status,
    input  logic signed [31:0]      s_offset_x,
    input  logic signed [31:0]      s_offset_y,
    input  logic signed [31:0]      s_offset_z,
    input  logic signed [31:0]      s_field_delta,
    output logic signed [31:0]      m_grad_x,
    output logic signed [31:0]      m_grad_y,
    output logic signed [31:0]      m_grad_z
);

    typedef struct packed {
        logic signed [63:0] xx;
        logic signed [63:0] xy;
        logic signed [63:0] xz;
        logic signed [63:0] yy;
        logic signed [63:0] yz;
        logic signed [63:0] zz;
        logic signed [63:0] rx;
        logic signed [63:0] ry;
        logic signed [63:0] rz;
    } sums_t;

    function automatic logic signed [63:0] pick_sum(input sums_t s, input logic [3:0] sel);
        logic signed [63:0] v;
        case (sel)
            lscg_pkg::SRC_XX: v = s.xx;
            lscg_pkg::SRC_XY: v = s.xy;
            lscg_pkg::SRC_XZ: v = s.xz;
            lscg_pkg::SRC_YY: v = s.yy;
            lscg_pkg::SRC_YZ: v = s.yz;
            lscg_pkg::SRC_ZZ: v = s.zz;
            lscg_pkg::SRC_RX: v = s.rx;
            lscg_pkg::SRC_RY: v = s.ry;
            lscg_pkg::SRC_RZ: v = s.rz;
            default:          v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            s = {1'b0, {63{1'b1}}};
        end else if (a[63] && b[63] && !s[63]) begin
            s = {1'b1, {63{1'b0}}};
        end
        return s;
    endfunction

    logic signed [31:0]     op_x_reg, op_y_reg, op_z_reg, op_d_reg;
    logic signed [63:0]     prod_reg;
    sums_t                  sums_reg, sums_next;
    logic signed [31:0]     mul_a, mul_b;
    logic signed [63:0]     prod_next;
    logic signed [63:0]     add_old;

    logic signed [BIG_W-1:0] temp_reg [7];
    logic signed [BIG_W-1:0] mac_x_reg, mac_acc_reg;
    logic        [63:0]      mac_y_reg;
    logic                    mac_neg_reg;
    logic signed [BIG_W-1:0] mac_src;
    logic signed [BIG_W-1:0] mac_term;
    logic        [2:0]       t_rd;

    logic        [BIG_W-1:0] div_n_reg, div_r_reg, div_d_reg;
    logic                    div_neg_reg;
    logic signed [BIG_W-1:0] div_num;
    logic signed [BIG_W-1:0] div_den;
    logic        [BIG_W-1:0] r_shift;
    logic                    r_ge;
    logic                    round_up;
    logic                    q_big;
    logic        [31:0]      q_lim, q_mag, q_val;

    logic signed [31:0]      g_x_reg, g_y_reg, g_z_reg;
    logic signed [31:0]      m_grad_x_reg, m_grad_y_reg, m_grad_z_reg;

    always_comb begin
        case (cmd.mul_sel)
            lscg_pkg::SRC_XX: begin mul_a = op_x_reg; mul_b = op_x_reg; end
            lscg_pkg::SRC_XY: begin mul_a = op_x_reg; mul_b = op_y_reg; end
            lscg_pkg::SRC_XZ: begin mul_a = op_x_reg; mul_b = op_z_reg; end
            lscg_pkg::SRC_YY: begin mul_a = op_y_reg; mul_b = op_y_reg; end
            lscg_pkg::SRC_YZ: begin mul_a = op_y_reg; mul_b = op_z_reg; end
            lscg_pkg::SRC_ZZ: begin mul_a = op_z_reg; mul_b = op_z_reg; end
            lscg_pkg::SRC_RX: begin mul_a = op_x_reg; mul_b = op_d_reg; end
            lscg_pkg::SRC_RY: begin mul_a = op_y_reg; mul_b = op_d_reg; end
            lscg_pkg::SRC_RZ: begin mul_a = op_z_reg; mul_b = op_d_reg; end
            default:          begin mul_a = '0;       mul_b = '0;       end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign add_old   = pick_sum(sums_reg, cmd.add_sel);

    always_comb begin
        sums_next = sums_reg;
        if (cmd.sum_clear) begin
            sums_next = '0;
        end else if (cmd.add_en) begin
            case (cmd.add_sel)
                lscg_pkg::SRC_XX: sums_next.xx = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_XY: sums_next.xy = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_XZ: sums_next.xz = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_YY: sums_next.yy = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_YZ: sums_next.yz = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_ZZ: sums_next.zz = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_RX: sums_next.rx = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_RY: sums_next.ry = sat_add(add_old, prod_reg);
                lscg_pkg::SRC_RZ: sums_next.rz = sat_add(add_old, prod_reg);
                default:          sums_next = sums_reg;
            endcase
        end
    end

    assign t_rd = 3'(cmd.uop.x_sel - lscg_pkg::SRC_T0);

    always_comb begin
        if (cmd.uop.x_sel >= lscg_pkg::SRC_T0) begin
            mac_src = temp_reg[t_rd];
        end else begin
            mac_src = BIG_W'(pick_sum(sums_reg, cmd.uop.x_sel));
        end
    end

    assign mac_term = mac_y_reg[0] ? mac_x_reg : '0;

    assign div_num = mac_acc_reg <<< FRAC_BITS;
    assign div_den = temp_reg[lscg_pkg::DET_SLOT];
    assign r_shift = {div_r_reg[BIG_W-2:0], div_n_reg[BIG_W-1]};
    assign r_ge    = r_shift >= div_d_reg;
    assign round_up = {div_r_reg, 1'b0} >= {1'b0, div_d_reg};

    assign q_big = |div_n_reg[BIG_W-1:32];
    assign q_lim = div_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign q_mag = (q_big || (div_n_reg[31:0] > q_lim)) ? q_lim : div_n_reg[31:0];
    assign q_val = div_neg_reg ? (32'd0 - q_mag) : q_mag;

    assign status.det_zero = (div_den == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg <= '0;
        end else begin
            sums_reg <= sums_next;
        end

        if (cmd.capture) begin
            op_x_reg <= s_offset_x;
            op_y_reg <= s_offset_y;
            op_z_reg <= s_offset_z;
            op_d_reg <= s_field_delta;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end

        if (cmd.mac_load) begin
            mac_x_reg   <= mac_src;
            mac_y_reg   <= pick_sum(sums_reg, cmd.uop.y_sel);
            mac_neg_reg <= cmd.uop.neg;
            if (cmd.uop.clr) begin
                mac_acc_reg <= '0;
            end
        end else if (cmd.mac_step) begin
            if (mac_neg_reg ^ cmd.mac_top) begin
                mac_acc_reg <= mac_acc_reg - mac_term;
            end else begin
                mac_acc_reg <= mac_acc_reg + mac_term;
            end
            mac_x_reg <= mac_x_reg <<< 1;
            mac_y_reg <= mac_y_reg >> 1;
        end

        if (cmd.t_store) begin
            temp_reg[cmd.uop.dst] <= mac_acc_reg;
        end

        if (cmd.div_load) begin
            div_n_reg   <= div_num[BIG_W-1] ? (BIG_W'(0) - div_num) : div_num;
            div_d_reg   <= div_den[BIG_W-1] ? (BIG_W'(0) - div_den) : div_den;
            div_r_reg   <= '0;
            div_neg_reg <= div_num[BIG_W-1] ^ div_den[BIG_W-1];
        end else if (cmd.div_step) begin
            div_r_reg <= r_ge ? (r_shift - div_d_reg) : r_shift;
            div_n_reg <= {div_n_reg[BIG_W-2:0], r_ge};
        end else if (cmd.div_round) begin
            div_n_reg <= div_n_reg + BIG_W'(round_up);
        end

        if (cmd.g_clear) begin
            g_x_reg <= '0;
            g_y_reg <= '0;
            g_z_reg <= '0;
        end else if (cmd.div_write) begin
            case (cmd.uop.gidx)
                2'd0:    g_x_reg <= q_val;
                2'd1:    g_y_reg <= q_val;
                default: g_z_reg <= q_val;
            endcase
        end

        if (cmd.out_load) begin
            m_grad_x_reg <= g_x_reg;
            m_grad_y_reg <= g_y_reg;
            m_grad_z_reg <= g_z_reg;
        end
    end

    assign m_grad_x = m_grad_x_reg;
    assign m_grad_y = m_grad_y_reg;
    assign m_grad_z = m_grad_z_reg;

endmodule

// File: rtl/lscg_ctrl.sv
// ----------------------------------------------------------------------------
// Least-squares cell gradient controller
// Handshakes, neighbour counting and the solver micro-program sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "least_squares_cell_gradient_defines.svh"

module lscg_ctrl #(
    parameter int MAX_NEIGHBOURS = 12,
    parameter int BIG_W          = 210
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output lscg_pkg::dp_cmd_t       cmd,
    input  lscg_pkg::dp_status_t    status
);

    localparam int         CNT_W     = $clog2(BIG_W);
    localparam logic [4:0] COUNT_MAX = 5'(MAX_NEIGHBOURS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SOLVE,
        ST_MAC_LOAD,
        ST_MAC_RUN,
        ST_MAC_END,
        ST_DET_CHECK,
        ST_DIV_RUN,
        ST_DIV_ROUND,
        ST_DIV_WRITE,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [4:0]         pc_reg, pc_next;
    logic [4:0]         count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic [1:0]         dim_reg, dim_next;
    logic [1:0]         res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic               accept;
    lscg_pkg::uop_t     uop;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign uop     = lscg_pkg::uop_at(pc_reg);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pc_next       = pc_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        dim_next      = dim_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        cmd           = '0;
        cmd.uop       = uop;

        if (cfg_wr_en) begin
            dim_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    if (count_reg >= COUNT_MAX) begin
                        ovf_next = 1'b1;
                        if (s_last) begin
                            state_next = ST_SOLVE;
                        end
                    end else begin
                        count_next = count_reg + 5'd1;
                        last_next  = s_last;
                        cnt_next   = '0;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                cmd.mul_en  = (cnt_reg < CNT_W'(lscg_pkg::NUM_PAIRS));
                cmd.mul_sel = cnt_reg[3:0];
                cmd.add_en  = (cnt_reg != '0);
                cmd.add_sel = cnt_reg[3:0] - 4'd1;
                if (cnt_reg == CNT_W'(lscg_pkg::NUM_PAIRS)) begin
                    state_next = last_reg ? ST_SOLVE : ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SOLVE: begin
                cmd.g_clear = 1'b1;
                if (ovf_reg) begin
                    res_next   = lscg_pkg::STAT_OVF;
                    state_next = ST_OUT;
                end else begin
                    pc_next    = (dim_reg == lscg_pkg::DIM_2D) ? lscg_pkg::PC_2D
                                                               : lscg_pkg::PC_3D;
                    state_next = ST_MAC_LOAD;
                end
            end
            ST_MAC_LOAD: begin
                cmd.mac_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_MAC_RUN;
            end
            ST_MAC_RUN: begin
                cmd.mac_step = 1'b1;
                cmd.mac_top  = (cnt_reg == CNT_W'(lscg_pkg::MAC_BITS - 1));
                if (cmd.mac_top) begin
                    state_next = ST_MAC_END;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAC_END: begin
                case (uop.act)
                    lscg_pkg::UA_STORE: begin
                        cmd.t_store = 1'b1;
                        pc_next     = pc_reg + 5'd1;
                        state_next  = ST_MAC_LOAD;
                    end
                    lscg_pkg::UA_DET: begin
                        cmd.t_store = 1'b1;
                        state_next  = ST_DET_CHECK;
                    end
                    lscg_pkg::UA_DIV: begin
                        cmd.div_load = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV_RUN;
                    end
                    default: begin
                        pc_next    = pc_reg + 5'd1;
                        state_next = ST_MAC_LOAD;
                    end
                endcase
            end
            ST_DET_CHECK: begin
                if (status.det_zero) begin
                    res_next   = lscg_pkg::STAT_SING;
                    state_next = ST_OUT;
                end else begin
                    pc_next    = pc_reg + 5'd1;
                    state_next = ST_MAC_LOAD;
                end
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(BIG_W - 1)) begin
                    state_next = ST_DIV_ROUND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_ROUND: begin
                cmd.div_round = 1'b1;
                state_next    = ST_DIV_WRITE;
            end
            ST_DIV_WRITE: begin
                cmd.div_write = 1'b1;
                if (uop.fin) begin
                    res_next   = lscg_pkg::STAT_OK;
                    state_next = ST_OUT;
                end else begin
                    pc_next    = pc_reg + 5'd1;
                    state_next = ST_MAC_LOAD;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load  = 1'b1;
                    cmd.sum_clear = 1'b1;
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pc_reg       <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
            dim_reg      <= lscg_pkg::DIM_RESET;
            res_reg      <= lscg_pkg::STAT_OK;
            m_valid_reg  <= 1'b0;
            m_status_reg <= lscg_pkg::STAT_OK;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pc_reg       <= pc_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            last_reg     <= last_next;
            dim_reg      <= dim_next;
            res_reg      <= res_next;
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    `LSCG_ASSERT_NEXT(a_result_clears_cell, aclk, aresetn, cmd.out_load, (count_reg == '0) && !ovf_reg, "Cell state is not cleared after a result is loaded.")
    `LSCG_ASSERT_NEXT(a_full_sets_overflow, aclk, aresetn, accept && (count_reg >= COUNT_MAX), ovf_reg, "An item beyond the neighbour limit did not flag overflow.")
    `LSCG_ASSERT_NOW(a_divide_nonsingular, aclk, aresetn, cmd.div_write, !status.det_zero, "A gradient was written with a zero determinant.")

endmodule

// File: rtl/least_squares_cell_gradient.sv
// ----------------------------------------------------------------------------
// Least-squares cell gradient
// Accumulates the normal equations per cell and solves them by Cramer's rule.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// cfg      in   cfg_wr_en          cfg_wr_data (dimension)
// s_       in   s_valid / s_ready  offsets x, y, z, field delta, last
// m_       out  m_valid / m_ready  gradient x, y, z, status
//
// A neighbour is taken in one transfer and its products then run on the one 32x32
// multiplier; an item beyond the neighbour limit only flags overflow. The last item then
// runs the solver: a setup state, the shift-add MAC steps (24 in 3D, 6 in 2D), a
// determinant check, the divisions with their rounding and write steps (3 in 3D, 2 in
// 2D) and a state to load the result. Reset is synchronous.
// A held result stalls the block only once the next result is ready to load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_squares_cell_gradient #(
    parameter int MAX_NEIGHBOURS = 12,
    parameter int FRAC_BITS      = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_offset_x,
    input  logic signed [31:0] s_offset_y,
    input  logic signed [31:0] s_offset_z,
    input  logic signed [31:0] s_field_delta,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_grad_x,
    output logic signed [31:0] m_grad_y,
    output logic signed [31:0] m_grad_z,
    output logic [1:0]         m_status
);

    localparam int BIG_W = 194 + FRAC_BITS;

    lscg_pkg::dp_cmd_t    cmd;
    lscg_pkg::dp_status_t status;

    lscg_ctrl #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
        .BIG_W          (BIG_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .cmd         (cmd),
        .status      (status)
    );

    lscg_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .BIG_W     (BIG_W)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_offset_x    (s_offset_x),
        .s_offset_y    (s_offset_y),
        .s_offset_z    (s_offset_z),
        .s_field_delta (s_field_delta),
        .m_grad_x      (m_grad_x),
        .m_grad_y      (m_grad_y),
        .m_grad_z      (m_grad_z)
    );

endmodule

// File: tb/least_squares_cell_gradient_test.sv
// ----------------------------------------------------------------------------
// Least-squares cell gradient testbench
// Sends cells of neighbour offsets and field differences with random gaps on
// both channels, predicts each gradient with exact wide integer arithmetic
// and checks every result field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_squares_cell_gradient_test;

    localparam int NEIGHBOUR_LIMIT = 12;
    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 3000;
    localparam int PHASE_ITEMS = 140;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] delta;
        logic               last;
    } neighbour_t;

    typedef struct {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic [1:0]         status;
    } gradient_t;

    class gradient_scoreboard;
        logic signed [63:0] sxx, sxy, sxz, syy, syz, szz, rx, ry, rz;
        int unsigned count;
        bit overflow;
        logic [1:0] dimension;
        gradient_t expected_q[$];
        int errors;
        int cells;

        function new();
            clear_cell();
            dimension = lscg_pkg::DIM_RESET;
            errors = 0;
            cells = 0;
        endfunction

        function void clear_cell();
            sxx = 0; sxy = 0; sxz = 0; syy = 0; syz = 0; szz = 0;
            rx = 0; ry = 0; rz = 0;
            count = 0;
            overflow = 0;
        endfunction

        function logic signed [63:0] acc(logic signed [63:0] a, logic signed [31:0] p,
                                         logic signed [31:0] q);
            logic signed [63:0] wp;
            logic signed [63:0] wq;
            logic signed [64:0] s;
            wp = p;
            wq = q;
            s = 65'(a) + 65'(wp * wq);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return s[63:0];
        endfunction

        function wide_t det_of(wide_t m[3][3], bit two_d);
            if (two_d) return m[0][0] * m[1][1] - m[0][1] * m[1][0];
            return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
                 - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
                 + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        endfunction

        function logic signed [31:0] scaled_quotient(wide_t num, wide_t den);
            bit neg;
            logic [255:0] n, d, q, r, lim;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = n / d;
            r = n % d;
            if ((r << 1) >= d) q = q + 1;
            lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
            if (q > lim) q = lim;
            return neg ? -q[31:0] : q[31:0];
        endfunction

        function void note_transfer(neighbour_t it);
            gradient_t g;
            wide_t m[3][3];
            wide_t t[3][3];
            wide_t rhs[3];
            wide_t det;
            logic signed [31:0] gv[3];
            bit two_d;
            if (count >= NEIGHBOUR_LIMIT) begin
                overflow = 1;
            end else begin
                count++;
                sxx = acc(sxx, it.ox, it.ox);
                sxy = acc(sxy, it.ox, it.oy);
                sxz = acc(sxz, it.ox, it.oz);
                syy = acc(syy, it.oy, it.oy);
                syz = acc(syz, it.oy, it.oz);
                szz = acc(szz, it.oz, it.oz);
                rx = acc(rx, it.ox, it.delta);
                ry = acc(ry, it.oy, it.delta);
                rz = acc(rz, it.oz, it.delta);
            end
            if (!it.last) return;
            gv[0] = 0; gv[1] = 0; gv[2] = 0;
            g.status = lscg_pkg::STAT_OK;
            if (overflow) begin
                g.status = lscg_pkg::STAT_OVF;
            end else begin
                two_d = (dimension == lscg_pkg::DIM_2D);
                m[0][0] = sxx; m[0][1] = sxy; m[0][2] = sxz;
                m[1][0] = sxy; m[1][1] = syy; m[1][2] = syz;
                m[2][0] = sxz; m[2][1] = syz; m[2][2] = szz;
                rhs[0] = rx; rhs[1] = ry; rhs[2] = rz;
                det = det_of(m, two_d);
                if (det == 0) begin
                    g.status = lscg_pkg::STAT_SING;
                end else begin
                    for (int i = 0; i < (two_d ? 2 : 3); i++) begin
                        for (int r = 0; r < 3; r++)
                            for (int c = 0; c < 3; c++)
                                t[r][c] = (c == i) ? rhs[r] : m[r][c];
                        gv[i] = scaled_quotient(det_of(t, two_d) <<< FRAC, det);
                    end
                end
            end
            g.gx = gv[0]; g.gy = gv[1]; g.gz = gv[2];
            expected_q = {expected_q, g};
            cells++;
            clear_cell();
        endfunction

        function void check_result(gradient_t got);
            gradient_t exp_g;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no cell pending: gx=%0d gy=%0d gz=%0d status=%0d",
                         $time, got.gx, got.gy, got.gz, got.status);
                errors++;
                return;
            end
            exp_g = expected_q.pop_front();
            if (got.gx !== exp_g.gx) begin
                $display("%0t: grad_x expected %0d actual %0d", $time, exp_g.gx, got.gx);
                errors++;
            end
            if (got.gy !== exp_g.gy) begin
                $display("%0t: grad_y expected %0d actual %0d", $time, exp_g.gy, got.gy);
                errors++;
            end
            if (got.gz !== exp_g.gz) begin
                $display("%0t: grad_z expected %0d actual %0d", $time, exp_g.gz, got.gz);
                errors++;
            end
            if (got.status !== exp_g.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_g.status,
                         got.status);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic signed [31:0] s_offset_x, s_offset_y, s_offset_z, s_field_delta;
    logic s_last;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_grad_x, m_grad_y, m_grad_z;
    logic [1:0] m_status;

    gradient_scoreboard sb;
    bit no_idle;
    int stall_cycles;
    int sent_items;

    least_squares_cell_gradient u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_offset_x    (s_offset_x),
        .s_offset_y    (s_offset_y),
        .s_offset_z    (s_offset_z),
        .s_field_delta (s_field_delta),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_grad_x      (m_grad_x),
        .m_grad_y      (m_grad_y),
        .m_grad_z      (m_grad_z),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic signed [31:0] small_value();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3: return $urandom;
            default: return small_value();
        endcase
    endfunction

    task automatic send_neighbour(neighbour_t it);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_offset_x <= it.ox;
        s_offset_y <= it.oy;
        s_offset_z <= it.oz;
        s_field_delta <= it.delta;
        s_last <= it.last;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(it);
        sent_items++;
    endtask

    task automatic send_cell(int n, int kind);
        neighbour_t it;
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: begin
                    it.ox = any_value(); it.oy = any_value(); it.oz = any_value();
                end
                1: begin
                    it.ox = small_value(); it.oy = small_value(); it.oz = 0;
                end
                2: begin
                    it.ox = small_value(); it.oy = it.ox <<< 1; it.oz = small_value();
                end
                default: begin
                    it.ox = small_value(); it.oy = small_value(); it.oz = small_value();
                end
            endcase
            it.delta = ($urandom_range(0, 4) == 0) ? any_value() : small_value();
            it.last = (i == n - 1);
            send_neighbour(it);
        end
    endtask

    task automatic send_fixed(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic signed [31:0] d, logic l);
        neighbour_t it;
        it.ox = x; it.oy = y; it.oz = z; it.delta = d; it.last = l;
        send_neighbour(it);
    endtask

    task automatic drain_and_set(logic [1:0] dim);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= dim;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.dimension = dim;
    endtask

    initial begin
        gradient_t got;
        int gap;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.gx = m_grad_x; got.gy = m_grad_y; got.gz = m_grad_z; got.status = m_status;
            sb.check_result(got);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [1:0] dims[6];
        int n, kind, target;
        sb = new();
        no_idle = 0;
        sent_items = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_offset_x = '0;
        s_offset_y = '0;
        s_offset_z = '0;
        s_field_delta = '0;
        s_last = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Axis-aligned cell with unit offsets.
        send_fixed(32'sh0001_0000, 0, 0, 32'sh0002_0000, 0);
        send_fixed(0, 32'sh0001_0000, 0, -32'sh0003_0000, 0);
        send_fixed(0, 0, 32'sh0001_0000, 32'sh0000_8000, 1);
        // A lone neighbour cannot span the space.
        send_fixed(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1);
        // More neighbours than the limit allows.
        for (int i = 0; i < 13; i++)
            send_fixed(small_value(), small_value(), small_value(), small_value(), i == 12);
        // Extreme offsets drive the sums into saturation.
        send_fixed(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_fixed(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_fixed(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
        // Tiny offsets with a large difference force the gradient to clip.
        send_fixed(1, 0, 0, 32'sh7FFF_FFFF, 0);
        send_fixed(0, 1, 0, 32'sh8000_0000, 0);
        send_fixed(0, 0, 1, 32'sh7FFF_FFFF, 1);

        dims = '{lscg_pkg::DIM_RESET, lscg_pkg::DIM_2D, 2'd0, 2'd1,
                 lscg_pkg::DIM_2D, lscg_pkg::DIM_RESET};
        for (int p = 0; p < 6; p++) begin
            // The sender waits for every outstanding gradient before each write.
            drain_and_set(dims[p]);
            no_idle = (p == 2);
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) begin
                case ($urandom_range(0, 19))
                    0: n = $urandom_range(1, 2);
                    1: n = $urandom_range(12, 14);
                    default: n = $urandom_range(3, 8);
                endcase
                case ($urandom_range(0, 9))
                    0: kind = 0;
                    1: kind = 1;
                    2: kind = 2;
                    default: kind = 3;
                endcase
                send_cell(n, kind);
            end
        end
        no_idle = 0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Sent %0d neighbours in %0d cells over six dimension settings,",
                 sent_items, sb.cells);
        $display("including singular, overflowing and saturating cells.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/lscg_pkg.sv
rtl/lscg_datapath.sv
rtl/lscg_ctrl.sv
rtl/least_squares_cell_gradient.sv
tb/least_squares_cell_gradient_test.sv
